// ----- sv/windowed_weighted_centroid_defines.svh -----
// Assertion helpers for the file that checks this block.
`ifndef WINDOWED_WEIGHTED_CENTROID_DEFINES_SVH
`define WINDOWED_WEIGHTED_CENTROID_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/wwc_pkg.sv -----
package wwc_pkg;

  localparam int POS_W     = 16;
  localparam int FIELD_W   = 16;
  localparam int MEAN_W    = 16;
  localparam int STS_W     = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int MOM_W     = 64;
  localparam int WGT_W     = 48;
  localparam int DIV_CNT_W = $clog2(MOM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HI = 1'b1;

  localparam logic signed [POS_W-1:0] WIN_LO_RST = 16'sh8000;
  localparam logic signed [POS_W-1:0] WIN_HI_RST = 16'sh7FFF;

  localparam logic [STS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STS_W-1:0] STS_ZERO = 2'd1;
  localparam logic [STS_W-1:0] STS_SAT  = 2'd2;

  localparam logic [MOM_W-1:0]  POS_MAX_MAG = 64'd32767;
  localparam logic [MOM_W-1:0]  NEG_MAX_MAG = 64'd32768;
  localparam logic [MEAN_W-1:0] MEAN_MAX    = 16'h7FFF;
  localparam logic [MEAN_W-1:0] MEAN_MIN    = 16'h8000;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic prep;
    logic div_start;
    logic finish;
  } wwc_cmd_t;

  typedef struct packed {
    logic last;
    logic zero_w;
    logic div_done;
    logic out_free;
  } wwc_sts_t;

endpackage

// ----- sv/wwc_if.sv -----
interface wwc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wwc_pkg::POS_W-1:0]      position;
  logic signed [wwc_pkg::FIELD_W-1:0]    field;
  logic                                  last_point;

  modport source(output valid, position, field, last_point, input ready);
  modport sink(input valid, position, field, last_point, output ready);
endinterface

interface wwc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wwc_pkg::MEAN_W-1:0]     mean_position;
  logic        [wwc_pkg::STS_W-1:0]      status;

  modport source(output valid, mean_position, status, input ready);
  modport sink(input valid, mean_position, status, output ready);
endinterface

// ----- sv/windowed_weighted_centroid.sv -----
// Each request is captured (products), then multiply-accumulated; no new request is
// accepted in between. A request with last_point set adds the sum hand-off and a
// bit-serial divide (skipped if the weight is 0) before the result is written out.
// The result sits in an output register while the next set is accepted.
// Reset (rst_n, synchronous, active low) clears sums, control and the output valid,
// and sets the window to its full open range.
`include "windowed_weighted_centroid_defines.svh"

module windowed_weighted_centroid #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  wwc_in_if.sink                            in_chan,
  wwc_out_if.source                         out_chan,
  input  logic                              cfg_wr_en,
  input  logic [wwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wwc_pkg::CFG_W-1:0]         cfg_wdata
);

  wwc_pkg::wwc_cmd_t cmd;
  wwc_pkg::wwc_sts_t sts;

  wwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wwc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_position       (in_chan.position),
    .in_field          (in_chan.field),
    .in_last_point     (in_chan.last_point),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_mean_position (out_chan.mean_position),
    .out_status        (out_chan.status)
  );

  `WWC_ASSERT_NEXT(a_busy_after_req, in_chan.valid && in_chan.ready, !in_chan.ready,
    "request accepted back to back")
  `WWC_ASSERT_NOW(a_cmd_excl, 1'b1,
    $onehot0({cmd.capture, cmd.accumulate, cmd.prep, cmd.finish}), "commands overlap")
  `WWC_ASSERT_NOW(a_zero_mean, out_chan.valid && out_chan.status == wwc_pkg::STS_ZERO,
    out_chan.mean_position == '0, "zero weight with nonzero mean")
  `WWC_ASSERT_NOW(a_sat_mean, out_chan.valid && out_chan.status == wwc_pkg::STS_SAT,
    out_chan.mean_position == wwc_pkg::MEAN_MAX || out_chan.mean_position == wwc_pkg::MEAN_MIN,
    "saturated mean off the rail")

endmodule

// ----- sv/wwc_div.sv -----
module wwc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wwc_pkg::MOM_W-1:0]   dividend,
  input  logic [wwc_pkg::WGT_W-1:0]   divisor,
  output logic [wwc_pkg::MOM_W-1:0]   quot,
  output logic                        done
);

  localparam int MW = wwc_pkg::MOM_W;
  localparam int WW = wwc_pkg::WGT_W;
  localparam int CW = wwc_pkg::DIV_CNT_W;

  logic [MW-1:0] dvd_r, dvd_nxt;
  logic [WW-1:0] dvs_r;
  logic [WW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [WW:0]   trial;
  logic [WW+1:0] diff;
  logic          ge;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial   = {rem_r, dvd_r[MW-1]};
    diff    = {1'b0, trial} - {2'b00, dvs_r};
    ge      = ~diff[WW+1];
    rem_nxt = ge ? diff[WW-1:0] : trial[WW-1:0];
    dvd_nxt = {dvd_r[MW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {CW{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = dvd_r;
  assign done = done_r;

endmodule

// ----- sv/wwc_dp.sv -----
module wwc_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wwc_pkg::wwc_cmd_t                   cmd,
  output wwc_pkg::wwc_sts_t                   sts,
  input  logic signed [wwc_pkg::POS_W-1:0]    in_position,
  input  logic signed [wwc_pkg::FIELD_W-1:0]  in_field,
  input  logic                                in_last_point,
  input  logic                                cfg_wr_en,
  input  logic [wwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wwc_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [wwc_pkg::MEAN_W-1:0]   out_mean_position,
  output logic [wwc_pkg::STS_W-1:0]           out_status
);

  localparam int SB  = SAMPLE_BITS;
  localparam int DW  = SB + 1;
  localparam int PW  = 2 * SB;
  localparam int SW  = 2 * SB + 1;
  localparam int MPW = 3 * SB + 2;
  localparam int WPW = 2 * SB + 2;
  localparam int MW  = wwc_pkg::MOM_W;
  localparam int WW  = wwc_pkg::WGT_W;
  localparam int XW  = wwc_pkg::POS_W;

  logic signed [XW-1:0]  win_lo_r, win_hi_r;
  logic signed [SB-1:0]  prev_x_r, prev_b_r;
  logic                  have_prev_r;
  logic signed [SB-1:0]  x1, b1;
  logic signed [PW-1:0]  p0_r, p1_r;
  logic signed [DW-1:0]  dx_r, bs_r;
  logic                  pair_ok_r, last_r;
  logic signed [SW-1:0]  msum;
  logic signed [MPW-1:0] mom;
  logic signed [WPW-1:0] wt;
  logic [MW-1:0]         moment_r;
  logic [WW-1:0]         weight_r;
  logic [MW-1:0]         mmag;
  logic [WW-1:0]         wmag;
  logic                  neg_r, zero_r;
  logic [MW-1:0]         quot;
  logic                  div_done;
  logic                  in_win;
  logic                  out_valid_r;
  logic [wwc_pkg::MEAN_W-1:0] out_mean_r, mean_nxt;
  logic [wwc_pkg::STS_W-1:0]  out_status_r, status_nxt;

  assign x1 = in_position[SB-1:0];
  assign b1 = in_field[SB-1:0];

  assign in_win = have_prev_r && (win_lo_r < XW'(prev_x_r)) && (XW'(prev_x_r) < win_hi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_lo_r <= wwc_pkg::WIN_LO_RST;
      win_hi_r <= wwc_pkg::WIN_HI_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wwc_pkg::CFG_WIN_LO: win_lo_r <= cfg_wdata;
        wwc_pkg::CFG_WIN_HI: win_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // First half of a request: per-point products, position difference and field sum.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p0_r      <= PW'(prev_x_r) * PW'(prev_b_r);
      p1_r      <= PW'(x1) * PW'(b1);
      dx_r      <= DW'(x1) - DW'(prev_x_r);
      bs_r      <= DW'(b1) + DW'(prev_b_r);
      pair_ok_r <= in_win;
      last_r    <= in_last_point;
      prev_x_r  <= x1;
      prev_b_r  <= b1;
    end
  end

  always_comb begin
    msum = SW'(p0_r) + SW'(p1_r);
    mom  = MPW'(dx_r) * MPW'(msum);
    wt   = WPW'(dx_r) * WPW'(bs_r);
    mmag = moment_r[MW-1] ? (~moment_r + 1'b1) : moment_r;
    wmag = weight_r[WW-1] ? (~weight_r + 1'b1) : weight_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      moment_r    <= '0;
      weight_r    <= '0;
    end else if (cmd.prep) begin
      // Sums handed to the divider; start a fresh set.
      have_prev_r <= 1'b0;
      moment_r    <= '0;
      weight_r    <= '0;
    end else begin
      if (cmd.capture) begin
        have_prev_r <= 1'b1;
      end
      if (cmd.accumulate && pair_ok_r) begin
        moment_r <= moment_r + MW'(mom);
        weight_r <= weight_r + WW'(wt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg_r  <= moment_r[MW-1] ^ weight_r[WW-1];
      zero_r <= (weight_r == '0);
    end
  end

  wwc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mmag),
    .divisor  (wmag),
    .quot     (quot),
    .done     (div_done)
  );

  // Saturate the signed quotient into the position range; zero weight gives mean 0.
  always_comb begin
    mean_nxt   = '0;
    status_nxt = wwc_pkg::STS_OK;
    priority if (zero_r) begin
      status_nxt = wwc_pkg::STS_ZERO;
    end else if (!neg_r) begin
      if (quot > wwc_pkg::POS_MAX_MAG) begin
        mean_nxt   = wwc_pkg::MEAN_MAX;
        status_nxt = wwc_pkg::STS_SAT;
      end else begin
        mean_nxt = quot[wwc_pkg::MEAN_W-1:0];
      end
    end else begin
      if (quot > wwc_pkg::NEG_MAX_MAG) begin
        mean_nxt   = wwc_pkg::MEAN_MIN;
        status_nxt = wwc_pkg::STS_SAT;
      end else begin
        mean_nxt = ~quot[wwc_pkg::MEAN_W-1:0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_mean_r   <= mean_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mean_position = out_mean_r;
  assign out_status        = out_status_r;

  assign sts.last     = last_r;
  assign sts.zero_w   = (weight_r == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = ~out_valid_r | out_ready;

endmodule

// ----- sv/wwc_ctrl.sv -----
module wwc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wwc_pkg::wwc_sts_t  sts,
  output wwc_pkg::wwc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_nxt      = sts.last ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        cmd.prep      = 1'b1;
        cmd.div_start = ~sts.zero_w;
        state_nxt     = sts.zero_w ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register can take the result.
        cmd.finish = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
